### sv/scal_pkg.sv
// Shared types and constants for the seconds-to-calendar converter.
package scal_pkg;

	localparam int SecsW = 31;
	localparam int DaysW = 15;
	localparam int TodW  = 17;

	// Day split: secs / 86400 == (secs >> 7) / 675, reciprocal exact for 24-bit operands
	localparam int           DayShiftIn = 7;
	localparam logic [24:0]  DayRecip   = 25'd25451659;
	localparam int           DayRecipSh = 34;
	localparam logic [16:0]  SecsPerDay = 17'd86400;

	// x / 15 for x below 2**15 (used for /60 after a shift by two)
	localparam logic [15:0]  Div15Recip = 16'd34953;
	localparam int           Div15Sh    = 19;

	// x / 7 for x below 2**15
	localparam logic [15:0]  Div7Recip  = 16'd37450;
	localparam int           Div7Sh     = 18;

	// Four-year cycles counted from 2004-01-01 (a leap year)
	localparam logic [15:0]  CycleRecip = 16'd45934;
	localparam int           CycleSh    = 26;
	localparam logic [10:0]  CycleDays  = 11'd1461;
	localparam logic [10:0]  CycleOfs   = 11'd1096;
	localparam logic [11:0]  BaseYear   = 12'd2004;

	typedef struct packed {
		logic [DaysW-1:0] days;
		logic [TodW-1:0]  tod;
	} split_t;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [2:0] wday;
	} clock_t;

	typedef struct packed {
		logic [4:0]  mday;
		logic [3:0]  month;
		logic [11:0] year;
	} date_t;

endpackage

### sv/scal_day_split.sv
// Front pipeline: split a second count into whole days and second of day.
module scal_day_split (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [scal_pkg::SecsW-1:0] seconds_count,
	output logic                       valid,
	output scal_pkg::split_t           split
);
	import scal_pkg::*;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SecsW-1:0] secs_s1, secs_s2, secs_s3;
	logic [48:0]      prod_s2;
	logic [DaysW-1:0] days_s3, days_s4;
	logic [TodW-1:0]  tod_s4;
	logic [48:0]      prod_d;
	logic [SecsW-1:0] day_secs_d;

	assign prod_d     = 49'(secs_s1[SecsW-1:DayShiftIn]) * 49'(DayRecip);
	assign day_secs_d = SecsW'(32'(days_s3) * 32'(SecsPerDay));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= load;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			secs_s1 <= seconds_count;
		end
		secs_s2 <= secs_s1;
		prod_s2 <= prod_d;
		secs_s3 <= secs_s2;
		days_s3 <= prod_s2[DayRecipSh +: DaysW];
		days_s4 <= days_s3;
		tod_s4  <= TodW'(secs_s3 - day_secs_d);
	end

	assign valid      = valid_s4;
	assign split.days = days_s4;
	assign split.tod  = tod_s4;
endmodule

### sv/scal_clock.sv
// Clock pipeline: second, minute, hour and weekday from the day split.
module scal_clock (
	input  logic             clk,
	input  scal_pkg::split_t split,
	output scal_pkg::clock_t clock
);
	import scal_pkg::*;

	logic [30:0]      minprod_s1, wkprod_s1;
	logic [TodW-1:0]  tod_s1;
	logic [DaysW-1:0] days_s1;
	logic [10:0]      mins_s2, mins_s3;
	logic [5:0]       sec_s2, sec_s3;
	logic [2:0]       wday_s2, wday_s3;
	logic [24:0]      hprod_s3;
	clock_t           out_s4, out_s5, out_s6;
	logic [10:0]      mins_d;
	logic [12:0]      wq_d;
	logic [4:0]       hour_d;

	assign mins_d = minprod_s1[Div15Sh +: 11];
	assign wq_d   = wkprod_s1[Div7Sh +: 13];
	assign hour_d = hprod_s3[Div15Sh +: 5];

	always_ff @(posedge clk) begin
		minprod_s1 <= 31'(split.tod[TodW-1:2]) * 31'(Div15Recip);
		wkprod_s1  <= 31'(split.days) * 31'(Div7Recip);
		tod_s1     <= split.tod;
		days_s1    <= split.days;

		mins_s2 <= mins_d;
		sec_s2  <= 6'(tod_s1 - 17'(mins_d) * 17'd60);
		wday_s2 <= 3'(days_s1 - 15'(wq_d) * 15'd7 + 15'd1);

		hprod_s3 <= 25'(mins_s2[10:2]) * 25'(Div15Recip);
		mins_s3  <= mins_s2;
		sec_s3   <= sec_s2;
		wday_s3  <= wday_s2;

		out_s4.sec  <= sec_s3;
		out_s4.min  <= 6'(mins_s3 - 11'(hour_d) * 11'd60);
		out_s4.hour <= hour_d;
		out_s4.wday <= wday_s3;

		// align with the date pipeline
		out_s5 <= out_s4;
		out_s6 <= out_s5;
	end

	assign clock = out_s6;
endmodule

### sv/scal_date.sv
// Date pipeline: year, month and day of month from the whole-day count.
module scal_date (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_in,
	input  logic [scal_pkg::DaysW-1:0] days,
	output logic                       valid,
	output scal_pkg::date_t            date
);
	import scal_pkg::*;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [14:0] e_s1, e_s2;
	logic [30:0] prod_s2;
	logic [4:0]  cyc_s3;
	logic [10:0] rem_s3;
	logic [8:0]  doy_s4, doy_s5;
	logic        leap_s4, leap_s5;
	logic [11:0] year_s4, year_s5;
	logic [3:0]  month_s5;
	date_t       out_s6;
	logic [4:0]  cyc_d;
	logic [1:0]  yic_d;
	logic [10:0] ystart_d;
	logic [3:0]  cnt_d;

	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] s;
		case (idx)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && idx >= 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

	assign cyc_d = prod_s2[CycleSh +: 5];

	// year inside the four-year cycle; year zero is the leap year
	always_comb begin
		if (rem_s3 < 11'd366) begin
			yic_d    = 2'd0;
			ystart_d = 11'd0;
		end else if (rem_s3 < 11'd731) begin
			yic_d    = 2'd1;
			ystart_d = 11'd366;
		end else if (rem_s3 < CycleOfs) begin
			yic_d    = 2'd2;
			ystart_d = 11'd731;
		end else begin
			yic_d    = 2'd3;
			ystart_d = CycleOfs;
		end
	end

	// count month starts already passed, compared side by side
	always_comb begin
		cnt_d = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s4 >= month_start(4'(i), leap_s4)) begin
				cnt_d = cnt_d + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		e_s1    <= days + 15'(CycleOfs);
		e_s2    <= e_s1;
		prod_s2 <= 31'(e_s1) * 31'(CycleRecip);

		cyc_s3 <= cyc_d;
		rem_s3 <= 11'(e_s2 - 15'(cyc_d) * 15'(CycleDays));

		doy_s4  <= 9'(rem_s3 - ystart_d);
		leap_s4 <= (yic_d == 2'd0);
		year_s4 <= BaseYear + {5'd0, cyc_s3, 2'd0} + 12'(yic_d);

		doy_s5   <= doy_s4;
		leap_s5  <= leap_s4;
		year_s5  <= year_s4;
		month_s5 <= cnt_d + 4'd1;

		out_s6.mday  <= 5'(doy_s5 - month_start(month_s5 - 4'd1, leap_s5) + 9'd1);
		out_s6.month <= month_s5;
		out_s6.year  <= year_s5;
	end

	assign valid = valid_s6;
	assign date  = out_s6;
endmodule

### sv/seconds_to_calendar_split.sv
// Top level of the seconds-to-calendar converter.
// Converts a count of seconds since 2007-01-01 00:00:00 into second, minute,
// hour, weekday (1 Monday .. 7 Sunday), day of month, month and year. The
// block is a ten-stage pipeline with no feedback: busy is always low, an item
// may be started in every cycle, and each item yields one result, shown for one
// cycle with done high. The depth is set by the chain of constant-reciprocal
// multiplies: four stages split the count into days and second of day (divide
// by 86400, then take the remainder), and six further stages run two branches
// side by side, one giving hour, minute, second and weekday, the other giving
// the four-year cycle, the year in it, the month and the day of month. Results
// leave in the order items entered; the receiver must take each result in its
// done cycle. Every 31-bit input maps to a valid date no later than 2075.
module seconds_to_calendar_split (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [scal_pkg::SecsW-1:0] seconds_count,
	output logic                       done,
	output logic [5:0]                 second_of_minute,
	output logic [5:0]                 minute_of_hour,
	output logic [4:0]                 hour_of_day,
	output logic [2:0]                 week_day,
	output logic [4:0]                 month_day,
	output logic [3:0]                 month_number,
	output logic [11:0]                year_number
);
	import scal_pkg::*;

	logic   split_valid;
	split_t split;
	clock_t clock;
	date_t  date;

	// never hold off an item: every stage advances each cycle
	assign busy = 1'b0;

	scal_day_split u_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (start),
		.seconds_count (seconds_count),
		.valid         (split_valid),
		.split         (split)
	);

	scal_clock u_clock (
		.clk   (clk),
		.split (split),
		.clock (clock)
	);

	// the date branch carries the valid bit; the clock branch keeps step
	scal_date u_date (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (split_valid),
		.days     (split.days),
		.valid    (done),
		.date     (date)
	);

	assign second_of_minute = clock.sec;
	assign minute_of_hour   = clock.min;
	assign hour_of_day      = clock.hour;
	assign week_day         = clock.wday;
	assign month_day        = date.mday;
	assign month_number     = date.month;
	assign year_number      = date.year;
endmodule

### sv/scal_checker.sv
// Port-level checks for the seconds-to-calendar converter, bound to the top level.
module scal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        done,
	input logic [5:0]  second_of_minute,
	input logic [5:0]  minute_of_hour,
	input logic [4:0]  hour_of_day,
	input logic [2:0]  week_day,
	input logic [4:0]  month_day,
	input logic [3:0]  month_number
);
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##10 done)
		else $error("item started without a result ten cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 10))
		else $error("result without a matching item");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (second_of_minute < 6'd60 && minute_of_hour < 6'd60 &&
			hour_of_day < 5'd24 && week_day != 3'd0))
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month_number != 4'd0 && month_number <= 4'd12 && month_day != 5'd0 &&
			(month_number != 4'd2 || month_day <= 5'd29)))
		else $error("date out of range");
endmodule

bind seconds_to_calendar_split scal_checker u_scal_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.done             (done),
	.second_of_minute (second_of_minute),
	.minute_of_hour   (minute_of_hour),
	.hour_of_day      (hour_of_day),
	.week_day         (week_day),
	.month_day        (month_day),
	.month_number     (month_number)
);

### verif/seconds_to_calendar_split_tb.sv
// Self-checking testbench for the seconds-to-calendar converter.
module seconds_to_calendar_split_tb;

	import scal_pkg::*;

	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned EPOCH_YEAR   = 2007;
	localparam int unsigned LAST_FULL_YEAR_OFS = 67; // 2074 is the last year fully in range
	localparam int          RANDOM_ITEMS = 1500;
	localparam int          DRAIN_LIMIT  = 2000;     // cycles allowed for results to come home
	localparam int          TAIL_CYCLES  = 20;       // pipeline depth is ten

	// One calendar result, packed in the order of the result ports.
	typedef struct packed {
		logic [5:0]  second_of_minute;
		logic [5:0]  minute_of_hour;
		logic [4:0]  hour_of_day;
		logic [2:0]  week_day;
		logic [4:0]  month_day;
		logic [3:0]  month_number;
		logic [11:0] year_number;
	} calendar_t;

	// Holds the calendar dates that accepted items must produce, oldest first.
	class calendar_scoreboard;
		calendar_t expected_dates[$];
		int        failures;

		function new();
			failures = 0;
		endfunction

		// Leap years are 2008, 2012, ... i.e. offset plus three divisible by four.
		static function int unsigned year_days(int unsigned year_ofs);
			return ((year_ofs + 3) % 4 == 0) ? 366 : 365;
		endfunction

		static function int unsigned month_days(int unsigned year_ofs, int unsigned month_idx);
			int unsigned lens[12];
			lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			if (month_idx == 1 && year_days(year_ofs) == 366)
				return 29;
			return lens[month_idx];
		endfunction

		// Split a second count into time of day, weekday and calendar date.
		function calendar_t split_seconds(logic [SecsW-1:0] secs);
			int unsigned day_idx;
			int unsigned year_ofs;
			int unsigned month_idx;
			calendar_t   date;
			day_idx               = secs / SECS_PER_DAY;
			date.second_of_minute = 6'(secs % 60);
			date.minute_of_hour   = 6'((secs / 60) % 60);
			date.hour_of_day      = 5'((secs / 3600) % 24);
			date.week_day         = 3'((day_idx % 7) + 1);
			// Remove whole years while the day index reaches past the year's length.
			year_ofs = 0;
			while (day_idx >= year_days(year_ofs)) begin
				day_idx -= year_days(year_ofs);
				year_ofs++;
			end
			// December takes whatever is left.
			month_idx = 0;
			while (month_idx < 11 && day_idx >= month_days(year_ofs, month_idx)) begin
				day_idx -= month_days(year_ofs, month_idx);
				month_idx++;
			end
			date.month_day    = 5'(day_idx + 1);
			date.month_number = 4'(month_idx + 1);
			date.year_number  = 12'(EPOCH_YEAR + year_ofs);
			return date;
		endfunction

		function void note_seconds(logic [SecsW-1:0] secs);
			expected_dates.push_back(split_seconds(secs));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_date(calendar_t got);
			calendar_t want;
			if (expected_dates.size() == 0) begin
				$error("result strobe with no item pending");
				failures++;
				return;
			end
			want = expected_dates.pop_front();
			compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
			compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
			compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
			compare_field("week_day", want.week_day, got.week_day);
			compare_field("month_day", want.month_day, got.month_day);
			compare_field("month_number", want.month_number, got.month_number);
			compare_field("year_number", want.year_number, got.year_number);
		endfunction

		function int pending_count();
			return expected_dates.size();
		endfunction
	endclass

	// Drive every input to a known value from time zero; hold reset low.
	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             start         = 1'b0;
	logic [SecsW-1:0] seconds_count = '0;
	logic             busy;
	logic             done;
	logic [5:0]       second_of_minute;
	logic [5:0]       minute_of_hour;
	logic [4:0]       hour_of_day;
	logic [2:0]       week_day;
	logic [4:0]       month_day;
	logic [3:0]       month_number;
	logic [11:0]      year_number;

	calendar_scoreboard date_board = new();

	seconds_to_calendar_split DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.seconds_count    (seconds_count),
		.done             (done),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.week_day         (week_day),
		.month_day        (month_day),
		.month_number     (month_number),
		.year_number      (year_number)
	);

	always #5 clk = ~clk;

	// Sample at the rising edge, before any of this edge's updates land:
	// note an item when start meets a low busy, check a result when done is up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				date_board.note_seconds(seconds_count);
			if (done)
				date_board.check_date({second_of_minute, minute_of_hour, hour_of_day,
					week_day, month_day, month_number, year_number});
		end
	end

	// Seconds at a given year offset, day of that year and second of day.
	function automatic logic [SecsW-1:0] seconds_at(int unsigned year_ofs, int unsigned day_of_year,
		int unsigned tod);
		longint unsigned days;
		days = day_of_year;
		for (int unsigned y = 0; y < year_ofs; y++)
			days += calendar_scoreboard::year_days(y);
		return SecsW'(days * SECS_PER_DAY + tod);
	endfunction

	// Pick midnight, the last second of the day, or anything in between.
	function automatic int unsigned pick_tod();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return SECS_PER_DAY - 1;
			default: return $urandom_range(0, SECS_PER_DAY - 1);
		endcase
	endfunction

	// Mix full-range values with dates that sit on year and month edges.
	function automatic logic [SecsW-1:0] random_seconds();
		int unsigned year_ofs;
		int unsigned month_idx;
		int unsigned day_of_year;
		int unsigned kind;
		kind     = $urandom_range(0, 9);
		year_ofs = $urandom_range(0, LAST_FULL_YEAR_OFS);
		if (kind <= 3)
			return SecsW'($urandom());
		if (kind <= 6) begin
			// first or last day of a year
			day_of_year = $urandom_range(0, 1) ? calendar_scoreboard::year_days(year_ofs) - 1 : 0;
			return seconds_at(year_ofs, day_of_year, pick_tod());
		end
		if (kind <= 8) begin
			// first or last day of a month
			month_idx   = $urandom_range(0, 11);
			day_of_year = 0;
			for (int unsigned m = 0; m < month_idx; m++)
				day_of_year += calendar_scoreboard::month_days(year_ofs, m);
			if ($urandom_range(0, 1))
				day_of_year += calendar_scoreboard::month_days(year_ofs, month_idx) - 1;
			return seconds_at(year_ofs, day_of_year, pick_tod());
		end
		// near either end of the input range
		if ($urandom_range(0, 1))
			return SecsW'($urandom_range(0, 200000));
		return SecsW'({SecsW{1'b1}} - $urandom_range(0, 200000));
	endfunction

	// Offer one item and hold it until the edge that takes it.
	task automatic send_item(input logic [SecsW-1:0] secs);
		start         <= 1'b1;
		seconds_count <= secs;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles; call only with a count above zero.
	task automatic idle_for(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and wait, with a limit, until every result has come home.
	task automatic wait_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (date_board.pending_count() > 0 && guard < DRAIN_LIMIT);
	endtask

	initial begin
		logic [SecsW-1:0] directed_items[$];
		int               sent;
		int               burst;
		bit               paused;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: range ends, unit rollovers, Sunday, year and leap edges.
		directed_items = '{
			'0, 59, 60, 3599, 3600, SecsW'(SECS_PER_DAY - 1), SecsW'(SECS_PER_DAY),
			SecsW'(6 * SECS_PER_DAY + 43200),          // first Sunday
			seconds_at(0, 58, SECS_PER_DAY - 1),       // end of February 2007
			seconds_at(0, 59, 0),                      // 1 March 2007
			seconds_at(0, 364, SECS_PER_DAY - 1),      // last second of a common year
			seconds_at(1, 0, 0),                       // first second of a leap year
			seconds_at(1, 58, SECS_PER_DAY - 1),       // 28 February 2008
			seconds_at(1, 59, 0),                      // leap day
			seconds_at(1, 60, 0),                      // 1 March 2008
			seconds_at(1, 365, SECS_PER_DAY - 1),      // last day of a leap year
			seconds_at(2, 0, 0),
			seconds_at(LAST_FULL_YEAR_OFS, 364, SECS_PER_DAY - 1),
			31'h2AAA_AAAA, 31'h5555_5555, 31'h4000_0000,
			{SecsW{1'b1}}                              // largest count, January 2075
		};
		foreach (directed_items[i])
			send_item(directed_items[i]);
		idle_for(3);

		// Random part: bursts of random length with random gaps between them,
		// now and then a long burst with no idling at all.
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
			for (int i = 0; i < burst; i++)
				send_item(random_seconds());
			sent += burst;
			if (!paused && sent > RANDOM_ITEMS / 2) begin
				// hold off the sender until the pipeline has emptied
				wait_drained();
				paused = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 12));
			end
		end

		// Let the last results arrive, then watch for stray strobes.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (date_board.pending_count() != 0) begin
			$error("%0d expected results never arrived", date_board.pending_count());
			date_board.failures++;
		end

		if (date_board.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Stop a hung run well past the slowest correct one.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
